[hw/rtl/ssp_pkg.sv]
// Package for the scan step to Cartesian point converter.
// Holds CORDIC constants, register indexes and datapath widths.
// No dependencies.
package ssp_pkg;

  localparam int CORDIC_ITERS = 28;
  localparam int XW = 48;
  localparam int ZW = 33;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'h26DD3B6A;

  localparam logic [31:0] ATAN_TURN32 [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_STEP   = 3'd0,
    REG_TOTAL_STEPS  = 3'd1,
    REG_FIRST_STEP   = 3'd2,
    REG_LAST_STEP    = 3'd3,
    REG_RANGE_CAP    = 3'd4,
    REG_ROT_OFS      = 3'd5,
    REG_OFFSET_X     = 3'd6,
    REG_OFFSET_Y     = 3'd7
  } reg_idx_t;

endpackage

[hw/rtl/ssp_div_cell.sv]
// One restoring division cell: one quotient bit per stage.
// Part of the chain that forms the rounded step angle; does not use ssp_pkg.
module ssp_div_cell #(
  parameter int SB = 12,
  parameter int AB = 16,
  parameter int NW = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [SB:0]   div,
  input  logic          v_i,
  input  logic [NW-1:0] num_i,
  input  logic [SB+1:0] rem_i,
  input  logic [AB-1:0] quot_i,
  input  logic          neg_i,
  input  logic          zero_i,
  input  logic [15:0]   d_i,
  output logic          v_o,
  output logic [NW-1:0] num_o,
  output logic [SB+1:0] rem_o,
  output logic [AB-1:0] quot_o,
  output logic          neg_o,
  output logic          zero_o,
  output logic [15:0]   d_o
);

  logic [SB+1:0] t;
  logic          ge;

  always_comb begin
    t  = {rem_i[SB:0], num_i[NW-1]};
    ge = t >= {1'b0, div};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_o  <= num_i << 1;
      rem_o  <= ge ? (t - {1'b0, div}) : t;
      quot_o <= {quot_i[AB-2:0], ge};
      neg_o  <= neg_i;
      zero_o <= zero_i;
      d_o    <= d_i;
    end
  end

endmodule

[hw/rtl/ssp_cordic_cell.sv]
// One CORDIC rotation cell, iteration I.
// Uses ssp_pkg for widths and the arctangent table.
module ssp_cordic_cell #(
  parameter int I = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            v_i,
  input  logic signed [ssp_pkg::XW-1:0]   x_i,
  input  logic signed [ssp_pkg::XW-1:0]   y_i,
  input  logic signed [ssp_pkg::ZW-1:0]   z_i,
  input  logic [1:0]                      q_i,
  output logic                            v_o,
  output logic signed [ssp_pkg::XW-1:0]   x_o,
  output logic signed [ssp_pkg::XW-1:0]   y_o,
  output logic signed [ssp_pkg::ZW-1:0]   z_o,
  output logic [1:0]                      q_o
);

  localparam logic signed [ssp_pkg::ZW-1:0] ATN =
    ssp_pkg::ZW'(ssp_pkg::ATAN_TURN32[I]);

  logic signed [ssp_pkg::XW-1:0] dx, dy;

  always_comb begin
    dx = y_i >>> I;
    dy = x_i >>> I;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o <= q_i;
      if (!z_i[ssp_pkg::ZW-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ATN;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ATN;
      end
    end
  end

endmodule

[hw/rtl/scan_step_polar_to_cartesian.sv]
// Scan sample to Cartesian point converter, top level.
// Uses ssp_pkg, ssp_div_cell and ssp_cordic_cell.
//
// Usage:
// Input channel in_valid/in_stall carries a step number and a signed range in mm.
// Output channel out_valid/out_stall carries x_mm and y_mm, one point per sample.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), to be
// written by the user only while no sample is in flight; the block does not
// enforce it. Throughput: one sample per cycle while the output is not stalled.
// The pipeline is a clamp stage, a chain of STEP_BITS+ANGLE_BITS+2 restoring
// division cells (one quotient bit each), an angle and gain multiply stage, 28
// CORDIC cells and a rounding/output register.
// While the receiver stalls a waiting result, the whole pipeline holds and
// in_stall is raised; it drops in the cycle the result transfers.
// Reset clears all valid bits and loads the register defaults: front step
// 384, 1024 steps per turn, window 44..725, no range cap, zero offsets.
module scan_step_polar_to_cartesian #(
  parameter int STEP_BITS = 12,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [STEP_BITS-1:0]         in_step_number,
  input  logic signed [16:0]           in_range_mm,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [17:0]           out_x_mm,
  output logic signed [17:0]           out_y_mm,
  input  logic                         cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssp_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int SB = STEP_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int NW = SB + AB + 2;
  localparam int IT = ssp_pkg::CORDIC_ITERS;
  localparam int XW = ssp_pkg::XW;
  localparam int ZW = ssp_pkg::ZW;

  logic [SB-1:0]       front_step_r, total_steps_r, first_step_r, last_step_r;
  logic [15:0]         range_cap_r;
  logic signed [15:0]  rot_ofs_r;
  logic signed [16:0]  offset_x_r, offset_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_step_r   <= SB'(12'd384);
      total_steps_r  <= SB'(12'd1024);
      first_step_r   <= SB'(12'd44);
      last_step_r    <= SB'(12'd725);
      range_cap_r    <= '0;
      rot_ofs_r      <= '0;
      offset_x_r     <= '0;
      offset_y_r     <= '0;
    end else if (cfg_we) begin
      unique case (ssp_pkg::reg_idx_t'(cfg_index))
        ssp_pkg::REG_FRONT_STEP:   front_step_r   <= SB'(cfg_wdata[11:0]);
        ssp_pkg::REG_TOTAL_STEPS:  total_steps_r  <= SB'(cfg_wdata[11:0]);
        ssp_pkg::REG_FIRST_STEP:   first_step_r   <= SB'(cfg_wdata[11:0]);
        ssp_pkg::REG_LAST_STEP:    last_step_r    <= SB'(cfg_wdata[11:0]);
        ssp_pkg::REG_RANGE_CAP:    range_cap_r    <= cfg_wdata[15:0];
        ssp_pkg::REG_ROT_OFS:      rot_ofs_r      <= cfg_wdata[15:0];
        ssp_pkg::REG_OFFSET_X:     offset_x_r     <= cfg_wdata;
        ssp_pkg::REG_OFFSET_Y:     offset_y_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // clamp stage
  logic [SB-1:0]  s_lo, s_cl, mag;
  logic           neg;
  logic [15:0]    d_cap;
  logic           v0_r, neg0_r, zero0_r;
  logic [NW-1:0]  num0_r;
  logic [15:0]    d0_r;

  always_comb begin
    s_lo = (in_step_number > last_step_r) ? last_step_r : in_step_number;
    s_cl = (s_lo < first_step_r) ? first_step_r : s_lo;
    neg  = s_cl < front_step_r;
    mag  = neg ? (front_step_r - s_cl) : (s_cl - front_step_r);
    if (in_range_mm[16]) begin
      d_cap = '0;
    end else if (range_cap_r != '0 && in_range_mm[15:0] > range_cap_r) begin
      d_cap = range_cap_r;
    end else begin
      d_cap = in_range_mm[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num0_r  <= (NW'(mag) << (AB + 1)) + NW'(total_steps_r);
      neg0_r  <= neg;
      zero0_r <= total_steps_r == '0;
      d0_r    <= d_cap;
    end
  end

  // division chain
  logic [SB:0]    div2;
  logic           dv   [NW+1];
  logic [NW-1:0]  dnum [NW+1];
  logic [SB+1:0]  drem [NW+1];
  logic [AB-1:0]  dquo [NW+1];
  logic           dneg [NW+1];
  logic           dzer [NW+1];
  logic [15:0]    dd   [NW+1];

  assign div2    = {total_steps_r, 1'b0};
  assign dv[0]   = v0_r;
  assign dnum[0] = num0_r;
  assign drem[0] = '0;
  assign dquo[0] = '0;
  assign dneg[0] = neg0_r;
  assign dzer[0] = zero0_r;
  assign dd[0]   = d0_r;

  for (genvar k = 0; k < NW; k++) begin : g_div
    ssp_div_cell #(.SB(SB), .AB(AB), .NW(NW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .div(div2),
      .v_i(dv[k]), .num_i(dnum[k]), .rem_i(drem[k]), .quot_i(dquo[k]),
      .neg_i(dneg[k]), .zero_i(dzer[k]), .d_i(dd[k]),
      .v_o(dv[k+1]), .num_o(dnum[k+1]), .rem_o(drem[k+1]), .quot_o(dquo[k+1]),
      .neg_o(dneg[k+1]), .zero_o(dzer[k+1]), .d_o(dd[k+1])
    );
  end

  // angle and gain stage
  logic [AB-1:0] a_raw, a_off, a_sum;
  logic [31:0]   a32, a32r, rr;
  logic [1:0]    quad;

  if (AB >= 16) begin : g_off_up
    assign a_off = AB'(rot_ofs_r) << (AB - 16);
  end else begin : g_off_dn
    logic signed [15:0] ao_sh;
    assign ao_sh = rot_ofs_r >>> (16 - AB);
    assign a_off = ao_sh[AB-1:0];
  end

  always_comb begin
    if (dzer[NW]) begin
      a_raw = '0;
    end else if (dneg[NW]) begin
      a_raw = -dquo[NW];
    end else begin
      a_raw = dquo[NW];
    end
    a_sum = a_raw + a_off;
    a32   = {a_sum, (32 - AB)'(0)};
    a32r  = a32 + 32'h2000_0000;
    quad  = a32r[31:30];
    rr    = a32 - {quad, 30'd0};
  end

  logic                 cv [IT+1];
  logic signed [XW-1:0] cx [IT+1];
  logic signed [XW-1:0] cy [IT+1];
  logic signed [ZW-1:0] cz [IT+1];
  logic [1:0]           cq [IT+1];
  logic                 va_r;
  logic signed [XW-1:0] xa_r;
  logic signed [ZW-1:0] za_r;
  logic [1:0]           qa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= dv[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa_r <= XW'(dd[NW] * ssp_pkg::CORDIC_GAIN_Q30);
      za_r <= ZW'($signed(rr));
      qa_r <= quad;
    end
  end

  assign cv[0] = va_r;
  assign cx[0] = xa_r;
  assign cy[0] = '0;
  assign cz[0] = za_r;
  assign cq[0] = qa_r;

  for (genvar i = 0; i < IT; i++) begin : g_cordic
    ssp_cordic_cell #(.I(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .v_i(cv[i]), .x_i(cx[i]), .y_i(cy[i]), .z_i(cz[i]), .q_i(cq[i]),
      .v_o(cv[i+1]), .x_o(cx[i+1]), .y_o(cy[i+1]), .z_o(cz[i+1]), .q_o(cq[i+1])
    );
  end

  // round, apply quadrant, translate
  logic signed [XW-1:0] xr, yr;
  logic signed [18:0]   c19, s19, rx, ry;
  logic                 out_valid_r;
  logic signed [17:0]   out_x_r, out_y_r;

  always_comb begin
    xr  = cx[IT] + XW'(64'sh2000_0000);
    yr  = cy[IT] + XW'(64'sh2000_0000);
    c19 = 19'(xr >>> 30);
    s19 = 19'(yr >>> 30);
    unique case (cq[IT])
      2'd0: begin rx = c19;  ry = s19;  end
      2'd1: begin rx = -s19; ry = c19;  end
      2'd2: begin rx = -c19; ry = -s19; end
      default: begin rx = s19; ry = -c19; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cv[IT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r <= 18'(rx + 19'(offset_x_r));
      out_y_r <= 18'(ry + 19'(offset_y_r));
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_mm  = out_x_r;
  assign out_y_mm  = out_y_r;

endmodule

[hw/rtl/ssp_checker.sv]
// Port-level checker for the scan step converter, bound to the top level.
// Depends on scan_step_polar_to_cartesian ports only.
module ssp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] out_x_mm,
  input logic signed [17:0] out_y_mm
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x_mm) && $stable(out_y_mm))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind scan_step_polar_to_cartesian ssp_checker u_ssp_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_x_mm(out_x_mm), .out_y_mm(out_y_mm)
);

[dv/scan_step_polar_to_cartesian_tb.sv]
// Testbench for scan_step_polar_to_cartesian: drives scan samples with bursty
// traffic and checks every point against a bit-exact CORDIC predictor or a table of known points.
// Depends on ssp_pkg and the scan_step_polar_to_cartesian RTL.
`timescale 1ns / 100ps

module scan_step_polar_to_cartesian_tb;

  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RAND_PER_PHASE = 100;
  localparam int NUM_PHASES = 7;

  typedef struct {
    logic signed [17:0] x;
    logic signed [17:0] y;
  } point_t;

  typedef struct {
    logic [11:0]        step;
    logic signed [16:0] range;
    bit                 known;
    logic signed [17:0] x;
    logic signed [17:0] y;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_step_number = '0;
  logic signed [16:0] in_range_mm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] out_x_mm;
  logic signed [17:0] out_y_mm;
  logic cfg_we = 1'b0;
  logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index = ssp_pkg::REG_FRONT_STEP;
  logic [ssp_pkg::CFG_W-1:0] cfg_wdata = '0;

  // predictor copy of the register file
  logic [11:0] front_step, total_steps, first_step, last_step;
  logic [15:0] range_cap;
  logic signed [15:0] rot_ofs;
  logic signed [16:0] offset_x, offset_y;

  point_t pending_points[$];
  int errors = 0;
  int samples_sent = 0;
  int points_checked = 0;
  int idle_cycles = 0;
  int stall_pct = 0;

  logic [31:0] atan_tbl [28] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  logic signed [16:0] phase_regs [NUM_PHASES][8] = '{
    '{17'sd0, 17'sd1, 17'sd0, 17'sd4095, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd4095, 17'sd4095, 17'sd0, 17'sd4095, 17'sd65535, 17'sd32767,
      17'sd65535, 17'sd65535},
    '{17'sd0, 17'sd4095, 17'sd4095, 17'sd0, 17'sd1, -17'sd32768,
      -17'sd65536, -17'sd65536},
    '{17'sd2048, 17'sd0, 17'sd100, 17'sd4000, 17'sd1000, 17'sd12345,
      -17'sd500, 17'sd700},
    '{17'sd384, 17'sd1081, 17'sd0, 17'sd4095, 17'sd30000, -17'sd1000,
      17'sd1234, -17'sd4321},
    '{17'sd1000, 17'sd360, 17'sd500, 17'sd1500, 17'sd0, 17'sd16384,
      17'sd0, 17'sd0},
    '{17'sd384, 17'sd1024, 17'sd44, 17'sd725, 17'sd0, 17'sd0, 17'sd0, 17'sd0}
  };

  sample_row_t reset_rows [14] = '{
    '{12'd384, 17'sd0, 1'b1, 18'sd0, 18'sd0},
    '{12'd384, -17'sd1, 1'b1, 18'sd0, 18'sd0},
    '{12'd384, -17'sd65536, 1'b1, 18'sd0, 18'sd0},
    '{12'd0, 17'sd0, 1'b1, 18'sd0, 18'sd0},
    '{12'd384, 17'sd1000, 1'b1, 18'sd1000, 18'sd0},
    '{12'd384, 17'sd65535, 1'b1, 18'sd65535, 18'sd0},
    '{12'd0, 17'sd65535, 1'b0, 18'sd0, 18'sd0},
    '{12'd4095, 17'sd65535, 1'b0, 18'sd0, 18'sd0},
    '{12'd44, 17'sd1, 1'b0, 18'sd0, 18'sd0},
    '{12'd725, 17'sd12345, 1'b0, 18'sd0, 18'sd0},
    '{12'd640, 17'sd5000, 1'b0, 18'sd0, 18'sd0},
    '{12'd128, 17'sd5000, 1'b0, 18'sd0, 18'sd0},
    '{12'd2730, -17'sd12, 1'b0, 18'sd0, 18'sd0},
    '{12'd1365, 17'sd43690, 1'b0, 18'sd0, 18'sd0}
  };

  scan_step_polar_to_cartesian i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_step_number (in_step_number),
    .in_range_mm    (in_range_mm),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_mm       (out_x_mm),
    .out_y_mm       (out_y_mm),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic point_t polar_to_point(logic [11:0] step, logic signed [16:0] range);
    longint s, idx, m, qt, d, x, y, z, c, sn, rx, ry, dx, dy;
    logic [15:0] ang;
    logic [31:0] a32, rr;
    logic [1:0] quad;
    point_t p;
    s = step;
    if (s > last_step) s = last_step;
    if (s < first_step) s = first_step;
    idx = s - longint'(front_step);
    ang = '0;
    if (total_steps != 0) begin
      m = (idx < 0 ? -idx : idx) << 16;
      qt = (2 * m + total_steps) / (2 * longint'(total_steps));
      ang = idx < 0 ? 16'(-qt) : 16'(qt);
    end
    ang = ang + rot_ofs;
    a32 = {ang, 16'h0};
    quad = 2'((a32 + 33'h20000000) >> 30);
    rr = a32 - {quad, 30'h0};
    z = longint'(signed'(rr));
    d = range > 0 ? longint'(range) : 0;
    if (range_cap != 0 && d > range_cap) d = range_cap;
    x = d * 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_tbl[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_tbl[i]);
      end
    end
    c = (x + (64'sd1 <<< 29)) >>> 30;
    sn = (y + (64'sd1 <<< 29)) >>> 30;
    case (quad)
      2'd0: begin rx = c; ry = sn; end
      2'd1: begin rx = -sn; ry = c; end
      2'd2: begin rx = -c; ry = -sn; end
      default: begin rx = sn; ry = -c; end
    endcase
    p.x = 18'(rx + offset_x);
    p.y = 18'(ry + offset_y);
    return p;
  endfunction

  // caller drops cfg_we after the last write
  task automatic write_reg(ssp_pkg::reg_idx_t idx, logic signed [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      ssp_pkg::REG_FRONT_STEP:   front_step = val[11:0];
      ssp_pkg::REG_TOTAL_STEPS:  total_steps = val[11:0];
      ssp_pkg::REG_FIRST_STEP:   first_step = val[11:0];
      ssp_pkg::REG_LAST_STEP:    last_step = val[11:0];
      ssp_pkg::REG_RANGE_CAP:    range_cap = val[15:0];
      ssp_pkg::REG_ROT_OFS:      rot_ofs = val[15:0];
      ssp_pkg::REG_OFFSET_X:     offset_x = val;
      default:                   offset_y = val;
    endcase
  endtask

  // hold the sample until transfer, then sometimes idle for a random gap
  task automatic send_sample(logic [11:0] step, logic signed [16:0] range, bit known,
                             point_t known_pt);
    int gap;
    in_valid <= 1'b1;
    in_step_number <= step;
    in_range_mm <= range;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(known ? known_pt : polar_to_point(step, range));
    samples_sent++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    point_t exp_pt;
    if (out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d", $time, out_x_mm, out_y_mm);
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        points_checked++;
        if (out_x_mm !== exp_pt.x) begin
          $display("%0t: x_mm expected %0d actual %0d", $time, exp_pt.x, out_x_mm);
          errors++;
        end
        if (out_y_mm !== exp_pt.y) begin
          $display("%0t: y_mm expected %0d actual %0d", $time, exp_pt.y, out_y_mm);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 3) * 25;
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || pending_points.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d points outstanding", $time,
               pending_points.size());
      $display("scan_step_polar_to_cartesian verification failed");
      $finish;
    end
  end

  initial begin
    point_t pt;
    logic [11:0] step;
    logic signed [16:0] range;
    front_step = 12'd384;
    total_steps = 12'd1024;
    first_step = 12'd44;
    last_step = 12'd725;
    range_cap = '0;
    rot_ofs = '0;
    offset_x = '0;
    offset_y = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (reset_rows[i]) begin
      pt.x = reset_rows[i].x;
      pt.y = reset_rows[i].y;
      send_sample(reset_rows[i].step, reset_rows[i].range, reset_rows[i].known, pt);
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int r = 0; r < 8; r++) write_reg(ssp_pkg::reg_idx_t'(r), phase_regs[ph][r]);
      cfg_we <= 1'b0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        case ($urandom_range(0, 3))
          0: step = 12'($urandom);
          1: step = first_step;
          2: step = last_step;
          default: step = 12'($urandom_range(first_step, 4095));
        endcase
        case ($urandom_range(0, 4))
          0: range = -17'sd1 - 17'($urandom_range(0, 65535));
          1: range = 17'(range_cap + $urandom_range(0, 2) - 1);
          default: range = 17'($urandom_range(0, 65535));
        endcase
        send_sample(step, range, 1'b0, pt);
      end
      drain();
    end

    $display("Sent %0d samples over %0d register settings, %0d points checked.",
             samples_sent, NUM_PHASES + 1, points_checked);
    if (errors == 0)
      $display("scan_step_polar_to_cartesian verification clean");
    else
      $display("scan_step_polar_to_cartesian verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_div_cell.sv
hw/rtl/ssp_cordic_cell.sv
hw/rtl/scan_step_polar_to_cartesian.sv
hw/rtl/ssp_checker.sv
dv/scan_step_polar_to_cartesian_tb.sv
